// ===== src/alnm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// alnm_pkg: shared types and constants of the access list name matcher
// Holds field widths, list encoding constants, the sequencer state type and
// the command/status bundles between controller and datapath.
// ============================================================================
package alnm_pkg;

    // Default list memory depth in bytes
    localparam int LIST_BYTES_DEF = 512;

    // Fixed field widths
    localparam int CFG_W  = 10;
    localparam int IDX_W  = 9;
    localparam int NAME_W = 64;

    // List entry encoding
    localparam int         HOST_BIT  = 7;
    localparam logic [7:0] STAR_CHAR = 8'h2A;

    // Transaction kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_HDR   = 6'b000100,
        ST_CHR   = 6'b001000,
        ST_EVAL  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    // Read address offset select, relative to the current entry position
    typedef enum logic [1:0] {
        RD_HDR  = 2'd0,
        RD_CHR0 = 2'd1,
        RD_NEXT = 2'd2
    } rd_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    load_wr;    // write one list byte
        logic    walk_init;  // latch query, size, clear position
        logic    rd_en;      // issue a list memory read
        rd_sel_t rd_sel;     // which byte to read
        logic    hdr_latch;  // capture entry header
        logic    chr_latch;  // capture one name character
        logic    eval_step;  // record hit, advance to next entry
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pos_lt_size;  // another entry may start
        logic fits;         // header's entry lies inside the list
        logic last_chr;     // character being captured is the last one
        logic hit;          // captured entry matches the query
    } status_t;

endpackage
`default_nettype wire

// ===== src/alnm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// alnm_ctrl: sequencer of the access list name matcher
// Walks list entries one byte per cycle by steering the datapath.
// ============================================================================
module alnm_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             kind,
    input  wire alnm_pkg::status_t status,
    output alnm_pkg::cmd_t         cmd,
    output logic                   busy,
    output logic                   done
);
    import alnm_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = start && (state_reg == ST_IDLE);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.rd_sel    = RD_HDR;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && kind == KIND_LOAD)
                begin
                    cmd.load_wr = 1'b1;
                end
                else if (accept && kind == KIND_QUERY)
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.pos_lt_size)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_HDR;
                    state_next = ST_HDR;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_HDR:
            begin
                if (status.fits)
                begin
                    cmd.hdr_latch = 1'b1;
                    cmd.rd_en     = 1'b1;
                    cmd.rd_sel    = RD_CHR0;
                    state_next    = ST_CHR;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CHR:
            begin
                cmd.chr_latch = 1'b1;
                if (status.last_chr)
                begin
                    state_next = ST_EVAL;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_NEXT;
                end
            end
            ST_EVAL:
            begin
                cmd.eval_step = 1'b1;
                state_next    = status.hit ? ST_DONE : ST_CHECK;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule
`default_nettype wire

// ===== src/alnm_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// alnm_dpath: datapath of the access list name matcher
// List memory, size register, entry position, name capture and compare.
// ============================================================================
module alnm_dpath #(
    parameter int LIST_BYTES = alnm_pkg::LIST_BYTES_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire alnm_pkg::cmd_t            cmd,
    input  wire logic                      cfg_we,
    input  wire logic [alnm_pkg::CFG_W-1:0] cfg_data,
    input  wire logic [alnm_pkg::IDX_W-1:0] byte_index,
    input  wire logic [7:0]                byte_value,
    input  wire logic [alnm_pkg::NAME_W-1:0] query_name,
    input  wire logic                      query_host,
    input  wire logic                      query_wild,
    output alnm_pkg::status_t              status,
    output logic                           outcome
);
    import alnm_pkg::*;

    localparam int ADDR_W = $clog2(LIST_BYTES);
    localparam int SZ_W   = ADDR_W + 1;
    localparam int CMP_W  = (SZ_W > CFG_W) ? SZ_W : CFG_W;
    localparam int WI_W   = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

    // List memory
    logic [7:0]        mem [LIST_BYTES];
    logic [7:0]        rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [WI_W-1:0]   wr_idx;
    logic              wr_en;

    // Walk state
    logic [CFG_W-1:0]  list_size_reg;
    logic              hit_reg;
    logic [SZ_W-1:0]   size_reg;
    logic [SZ_W-1:0]   pos_reg;
    logic [2:0]        len_m1_reg;
    logic [2:0]        cnt_reg;
    logic              ent_host_reg;
    logic [7:0]        last_chr_reg;
    logic [NAME_W-1:0] ent_name_reg;
    logic [NAME_W-1:0] q_name_reg;
    logic              q_host_reg;
    logic              q_wild_reg;

    logic [CMP_W-1:0]  eff_size;
    logic [3:0]        rd_off;
    logic [SZ_W-1:0]   rd_pos;
    logic [SZ_W:0]     ent_end;
    logic [NAME_W-1:0] pfx_mask;
    logic              ent_wild;

    // Load write decode: indexes past the memory are dropped
    assign wr_idx = WI_W'(byte_index);
    assign wr_en  = cmd.load_wr && ((WI_W+1)'(wr_idx) < (WI_W+1)'(LIST_BYTES));

    // Read address: entry position plus offset
    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_HDR:  rd_off = 4'd0;
            RD_CHR0: rd_off = 4'd1;
            RD_NEXT: rd_off = 4'(cnt_reg) + 4'd2;
            default: rd_off = 4'd0;
        endcase
    end
    assign rd_pos  = pos_reg + SZ_W'(rd_off);
    assign rd_addr = rd_pos[ADDR_W-1:0];

    // Memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx[ADDR_W-1:0]] <= byte_value;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Size register, clamped to the memory depth
    assign eff_size = (CMP_W'(list_size_reg) > CMP_W'(LIST_BYTES)) ?
                      CMP_W'(LIST_BYTES) : CMP_W'(list_size_reg);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_size_reg <= '0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                list_size_reg <= cfg_data;
            end
            if (cmd.walk_init)
            begin
                hit_reg <= 1'b0;
            end
            else if (cmd.eval_step && status.hit)
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    // Walk payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.walk_init)
        begin
            size_reg   <= eff_size[SZ_W-1:0];
            pos_reg    <= '0;
            q_name_reg <= query_name;
            q_host_reg <= query_host;
            q_wild_reg <= query_wild;
        end
        if (cmd.hdr_latch)
        begin
            len_m1_reg   <= rd_data_reg[2:0];
            ent_host_reg <= rd_data_reg[HOST_BIT];
            ent_name_reg <= '0;
            cnt_reg      <= '0;
        end
        if (cmd.chr_latch)
        begin
            ent_name_reg[8*cnt_reg +: 8] <= rd_data_reg;
            last_chr_reg                 <= rd_data_reg;
            cnt_reg                      <= cnt_reg + 3'd1;
        end
        if (cmd.eval_step)
        begin
            pos_reg <= pos_reg + SZ_W'(len_m1_reg) + SZ_W'(2);
        end
    end

    // Entry end check: header plus name must lie inside the list
    assign ent_end = (SZ_W+1)'(pos_reg) + (SZ_W+1)'(rd_data_reg[2:0]) + (SZ_W+1)'(2);

    // Prefix mask: the characters before the trailing star
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            pfx_mask[8*k +: 8] = (k < int'(len_m1_reg)) ? 8'hFF : 8'h00;
        end
    end

    assign ent_wild = (last_chr_reg == STAR_CHAR);

    // Status to the controller
    always_comb
    begin
        status.pos_lt_size = (pos_reg < size_reg);
        status.fits        = (ent_end <= (SZ_W+1)'(size_reg));
        status.last_chr    = (cnt_reg == len_m1_reg);
        status.hit         = 1'b0;
        if (ent_host_reg == q_host_reg)
        begin
            if (ent_wild == q_wild_reg)
            begin
                status.hit = (ent_name_reg == q_name_reg);
            end
            else if (ent_wild)
            begin
                status.hit = ((ent_name_reg & pfx_mask) == (q_name_reg & pfx_mask));
            end
        end
    end

    assign outcome = !hit_reg;

endmodule
`default_nettype wire

// ===== src/access_list_name_matcher_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// access_list_name_matcher_unit: access list name matcher, top level
// Stores a byte-packed list of variable-length name entries and answers
// whether a queried name with host and wildcard flags is allowed.
// ============================================================================
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-------------------------------------
//  command   | start / busy          | kind, byte_index, byte_value,
//            |                       | query_name, query_host, query_wild
//  result    | done (one cycle)      | outcome
//  config    | cfg_valid / cfg_ready | cfg_data (list_size)
//
//  A load transaction writes its byte at the accepting edge; busy stays low.
//  A query holds busy while it walks entries through check, header, one
//  character state per name character and evaluate, then while done is high
//  for one cycle; a walk at the list size ends after its check, an entry that
//  does not fit after check and header. The single read port reads one byte per cycle.
//  Reset is asynchronous; the list memory is not cleared and needs no
//  clearing pass. Results cannot be stalled.
//
module access_list_name_matcher_unit #(
    parameter int LIST_BYTES = alnm_pkg::LIST_BYTES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        kind,
    input  wire logic [alnm_pkg::IDX_W-1:0]  byte_index,
    input  wire logic [7:0]                  byte_value,
    input  wire logic [alnm_pkg::NAME_W-1:0] query_name,
    input  wire logic                        query_host,
    input  wire logic                        query_wild,
    output logic                             done,
    output logic                             outcome,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [alnm_pkg::CFG_W-1:0]  cfg_data
);
    import alnm_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Configuration is taken while no query is running
    assign cfg_ready = !busy;

    alnm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    alnm_dpath #(
        .LIST_BYTES (LIST_BYTES)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .byte_index (byte_index),
        .byte_value (byte_value),
        .query_name (query_name),
        .query_host (query_host),
        .query_wild (query_wild),
        .status     (status),
        .outcome    (outcome)
    );

endmodule
`default_nettype wire

// ===== src/alnm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// alnm_checker: port-level checks of the access list name matcher
// Watches command and result ports over time; bound to the top level.
// ============================================================================
module alnm_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic kind,
    input wire logic done,
    input wire logic cfg_ready
);
    import alnm_pkg::*;

    // A result only comes out of a running query
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    // The unit frees up right after the result
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!busy && !done))
        else $error("busy or done after result");

    // A load transaction does not occupy the unit
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_LOAD) |=> !busy)
        else $error("load made the unit busy");

    // A query transaction starts a walk
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_QUERY) |=> (busy && !done))
        else $error("query did not start a walk");

    // Configuration is refused exactly while busy
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready == !busy)
        else $error("cfg_ready out of step with busy");

endmodule

bind access_list_name_matcher_unit alnm_checker u_alnm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .kind      (kind),
    .done      (done),
    .cfg_ready (cfg_ready)
);
`default_nettype wire
